FILE: src/modular_exponentiation_unit_macros.svh
// assertion macros for the modular exponentiation unit
`ifndef MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MEU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MEU_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MEU_ASSERT(lbl, clk, rst_n, prop, msg)
`define MEU_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: src/modexp_pkg.sv
// shared types and constants of the modular exponentiation unit
package modexp_pkg;
  localparam int unsigned DefaultWidth = 64;
  localparam int unsigned RegW = 64;
  localparam logic IdxExponent = 1'b0;
  localparam logic IdxModulus  = 1'b1;

  // request to the modular multiplier
  typedef struct packed {
    logic start;
  } mm_ctrl_t;

  // sequencer states
  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StReduce = 7'b0000010,
    StMulA   = 7'b0000100,
    StWaitA  = 7'b0001000,
    StMulP   = 7'b0010000,
    StWaitP  = 7'b0100000,
    StDone   = 7'b1000000
  } state_e;
endpackage

FILE: src/modexp_mulmod.sv
// bit-serial modular multiplier: one double-and-add step per cycle
`include "modular_exponentiation_unit_macros.svh"
module modexp_mulmod #(
  parameter int unsigned WIDTH = modexp_pkg::DefaultWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  modexp_pkg::mm_ctrl_t ctrl_i,
  input  logic [WIDTH-1:0]    a_i,
  input  logic [WIDTH-1:0]    b_i,
  input  logic [WIDTH-1:0]    n_i,
  output logic                done_o,
  output logic [WIDTH-1:0]    p_o
);
  localparam int unsigned CntW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] acc_q, acc_d, b_q, b_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [WIDTH:0]   dbl, dbl_r, sum, sum_r;

  // one step: acc = 2*acc mod n, then add a if the bit is set
  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, n_i}) ? dbl - {1'b0, n_i} : dbl;
    sum   = dbl_r + {1'b0, a_i};
    sum_r = (sum >= {1'b0, n_i}) ? sum - {1'b0, n_i} : sum;
    acc_d  = acc_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      acc_d  = '0;
      b_d    = b_i;
      cnt_d  = CntW'(WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = b_q[WIDTH-1] ? sum_r[WIDTH-1:0] : dbl_r[WIDTH-1:0];
      b_d   = {b_q[WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

  `MEU_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q), "done without work")
  `MEU_ASSERT_NEVER(a_start_while_busy, clk_i, rst_ni, ctrl_i.start && busy_q, "start while busy")
  `MEU_ASSERT(a_cnt_idle, clk_i, rst_ni, !busy_q |-> cnt_q == '0 || done_q || $past(ctrl_i.start) == 1'b0, "count")
endmodule

FILE: src/modular_exponentiation_unit.sv
// Modular exponentiation, right-to-left square-and-multiply. An item takes
// start and then runs to completion: a restoring base reduction (one
// quotient bit a cycle), then for each exponent bit up to its highest set
// bit a squaring and, where the bit is set, a multiplication first, each in
// one shared bit-serial multiplier. A zero modulus or zero exponent goes
// straight to the done state and skips the reduction.
// The result shows for one cycle with done_o; the receiver cannot stall.
// Register writes are accepted only while the unit is not busy.
`include "modular_exponentiation_unit_macros.svh"
module modular_exponentiation_unit #(
  parameter int unsigned WIDTH = modexp_pkg::DefaultWidth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [WIDTH-1:0]           base_i,
  output logic                       done_o,
  output logic [WIDTH-1:0]           result_o,
  output logic                       modulus_zero_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [modexp_pkg::RegW-1:0] cfg_data_i
);
  localparam int unsigned CntW = $clog2(WIDTH + 1);

  modexp_pkg::state_e state_q, state_d;
  logic [WIDTH-1:0] exp_reg_q, mod_reg_q;
  logic [WIDTH-1:0] e_q, e_d, pw_q, pw_d, acc_q, acc_d, rem_q, rem_d, num_q, num_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WIDTH-1:0] res_q, res_d;
  logic             mz_q, mz_d, dn_q, dn_d;
  logic [WIDTH:0]   shl;
  logic             mm_done;
  logic [WIDTH-1:0] mm_p, mm_a, mm_b;
  modexp_pkg::mm_ctrl_t mm_ctrl;

  assign cfg_ready_o = !busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_reg_q <= '0;
      mod_reg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == modexp_pkg::IdxExponent) exp_reg_q <= cfg_data_i[WIDTH-1:0];
      else mod_reg_q <= cfg_data_i[WIDTH-1:0];
    end
  end

  modexp_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk_i, .rst_ni, .ctrl_i(mm_ctrl), .a_i(mm_a), .b_i(mm_b), .n_i(mod_reg_q),
    .done_o(mm_done), .p_o(mm_p)
  );

  assign shl = {rem_q, num_q[WIDTH-1]};

  // sequencer
  always_comb begin
    state_d = state_q;
    e_d = e_q; pw_d = pw_q; acc_d = acc_q; rem_d = rem_q; num_d = num_q;
    cnt_d = cnt_q; res_d = res_q; mz_d = mz_q; dn_d = 1'b0;
    mm_ctrl.start = 1'b0;
    mm_a = acc_q;
    mm_b = pw_q;
    unique case (state_q)
      modexp_pkg::StIdle: begin
        if (start) begin
          e_d = exp_reg_q;
          num_d = base_i;
          rem_d = '0;
          cnt_d = CntW'(WIDTH);
          acc_d = (mod_reg_q == WIDTH'(1) && exp_reg_q != '0) ? '0 : WIDTH'(1);
          if (mod_reg_q == '0 || exp_reg_q == '0) state_d = modexp_pkg::StDone;
          else state_d = modexp_pkg::StReduce;
        end
      end
      modexp_pkg::StReduce: begin
        // restoring remainder, one bit a cycle
        rem_d = (shl >= {1'b0, mod_reg_q}) ? WIDTH'(shl - {1'b0, mod_reg_q})
                                           : shl[WIDTH-1:0];
        num_d = {num_q[WIDTH-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          pw_d = rem_d;
          state_d = modexp_pkg::StMulA;
        end
      end
      modexp_pkg::StMulA: begin
        if (e_q == '0) state_d = modexp_pkg::StDone;
        else if (e_q[0]) begin
          mm_ctrl.start = 1'b1;
          state_d = modexp_pkg::StWaitA;
        end else state_d = modexp_pkg::StMulP;
      end
      modexp_pkg::StWaitA: begin
        if (mm_done) begin
          acc_d = mm_p;
          state_d = modexp_pkg::StMulP;
        end
      end
      modexp_pkg::StMulP: begin
        mm_a = pw_q;
        mm_ctrl.start = 1'b1;
        state_d = modexp_pkg::StWaitP;
      end
      modexp_pkg::StWaitP: begin
        mm_a = pw_q;
        if (mm_done) begin
          pw_d = mm_p;
          e_d = e_q >> 1;
          state_d = modexp_pkg::StMulA;
        end
      end
      modexp_pkg::StDone: begin
        mz_d = (mod_reg_q == '0);
        res_d = (mod_reg_q == '0) ? '0 : acc_q;
        dn_d = 1'b1;
        state_d = modexp_pkg::StIdle;
      end
      default: state_d = modexp_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= modexp_pkg::StIdle;
      dn_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      dn_q <= dn_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d; pw_q <= pw_d; acc_q <= acc_d; rem_q <= rem_d; num_q <= num_d;
    res_q <= res_d; mz_q <= mz_d;
  end

  assign busy = (state_q != modexp_pkg::StIdle);
  assign done_o = dn_q;
  assign result_o = res_q;
  assign modulus_zero_o = mz_q;

  `MEU_ASSERT(a_done_idle, clk_i, rst_ni, dn_q |-> state_q == modexp_pkg::StIdle, "done not idle")
  `MEU_ASSERT(a_done_after_fin, clk_i, rst_ni, dn_q |-> $past(state_q) == modexp_pkg::StDone, "done")
  `MEU_ASSERT(a_res_below_mod, clk_i, rst_ni, (dn_q && !mz_q && exp_reg_q != '0) |-> result_o < mod_reg_q, "range")
endmodule
